FILE: rtl/dsfn_pkg.sv
// Shared types and constants for the far-to-near distance sorter.
package dsfn_pkg;

    // Stored point: coordinates in signed Q11.4 plus the caller's tag
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [5:0]         tag;
    } point_t;

    localparam int KEY_W = 34;
    localparam int SQ_W  = 32;

    typedef logic [KEY_W-1:0] key_t;

    // Register indexes on the APB port
    localparam logic [1:0] REG_REF_X = 2'd0;
    localparam logic [1:0] REG_REF_Y = 2'd1;
    localparam logic [1:0] REG_REF_Z = 2'd2;

    // Axis select for the shared squaring unit
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic [1:0] AXIS_FLUSH = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_WRITE,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

FILE: rtl/dsfn_if.sv
// Valid/ready channel interfaces for point input and sorted output.
interface dsfn_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [5:0]         tag_in;
    logic               load_last;

    modport source (
        output valid, pos_x, pos_y, pos_z, tag_in, load_last,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, tag_in, load_last,
        output ready
    );
endinterface

interface dsfn_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic [5:0]         tag_out;
    logic [33:0]        dist_sq;
    logic               emit_last;

    modport source (
        output valid, out_x, out_y, out_z, tag_out, dist_sq, emit_last,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, tag_out, dist_sq, emit_last,
        output ready
    );
endinterface

FILE: rtl/distance_sort_far_to_near_core.sv
// Top level of the far-to-near distance sorter: sequencer, config regs, datapath.
//
// Points are loaded one per transfer. The next transfer is accepted only once the load
// is done, because one squaring unit handles x, y and z in turn before the
// point and its squared distance are written to the point memory. The transfer
// flagged load_last (itself loaded unless the store is full) starts emission:
// each result is found by one pass over the n stored points through the single
// memory read port and one key comparator, and is then offered as an output transfer.
// Results come out farthest first, equal distances in load order, with
// emit_last on the nearest. Points beyond MAX_POINTS in a set are dropped. The
// memory needs no clearing after reset; only entries of the current set are read.
module distance_sort_far_to_near_core #(
    parameter int MAX_POINTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    dsfn_in_if.sink     in_ch,
    dsfn_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dsfn_pkg::*;

    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int FILL_W = $clog2(MAX_POINTS + 1);

    state_t              state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic signed [15:0]  ref_x_reg, ref_y_reg, ref_z_reg;
    point_t              pt_reg, pt_next;
    logic                last_reg, last_next;
    logic [1:0]          axis_reg, axis_next;
    key_t                acc_reg, acc_next;
    logic [ADDR_W-1:0]   iss_addr_reg, iss_addr_next;
    logic                iss_done_reg, iss_done_next;
    logic                pend_reg, pend_next;
    logic [ADDR_W-1:0]   pend_idx_reg, pend_idx_next;
    logic                found_reg, found_next;
    key_t                best_key_reg, best_key_next;
    logic [ADDR_W-1:0]   best_idx_reg, best_idx_next;
    point_t              best_pt_reg, best_pt_next;
    logic                have_prev_reg, have_prev_next;
    key_t                prev_key_reg, prev_key_next;
    logic [ADDR_W-1:0]   prev_idx_reg, prev_idx_next;
    logic [FILL_W-1:0]   emit_cnt_reg, emit_cnt_next;

    logic signed [15:0]  sq_a, sq_b;
    logic [SQ_W-1:0]     sq;
    logic                wr_en;
    logic                rd_en;
    point_t              rd_point;
    key_t                rd_key;
    logic [FILL_W-1:0]   last_pos;
    logic                store_full;
    logic                cand_after;
    logic                cand_take;
    logic                emit_last;
    logic                cfg_wr;

    // APB configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_x_reg <= '0;
            ref_y_reg <= '0;
            ref_z_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_REF_X: ref_x_reg <= pwdata[15:0];
                REG_REF_Y: ref_y_reg <= pwdata[15:0];
                REG_REF_Z: ref_z_reg <= pwdata[15:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_REF_X: prdata = {16'd0, ref_x_reg};
            REG_REF_Y: prdata = {16'd0, ref_y_reg};
            REG_REF_Z: prdata = {16'd0, ref_z_reg};
            default:   prdata = '0;
        endcase
    end

    // Shared squaring unit, operands picked by axis
    always_comb
    begin
        case (axis_reg)
            AXIS_X:  begin sq_a = pt_reg.x; sq_b = ref_x_reg; end
            AXIS_Y:  begin sq_a = pt_reg.y; sq_b = ref_y_reg; end
            default: begin sq_a = pt_reg.z; sq_b = ref_z_reg; end
        endcase
    end

    dsfn_sq_unit u_sq (
        .clk (clk),
        .a   (sq_a),
        .b   (sq_b),
        .sq  (sq)
    );

    dsfn_store #(
        .DEPTH  (MAX_POINTS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (fill_reg[ADDR_W-1:0]),
        .wr_point (pt_reg),
        .wr_key   (acc_reg),
        .rd_en    (rd_en),
        .rd_addr  (iss_addr_reg),
        .rd_point (rd_point),
        .rd_key   (rd_key)
    );

    // Scan compare: next in order is the largest key below the last emitted,
    // equal keys taken by ascending index
    assign last_pos   = fill_reg - FILL_W'(1);
    assign store_full = (fill_reg >= FILL_W'(MAX_POINTS));
    assign cand_after = !have_prev_reg || (rd_key < prev_key_reg) ||
                        ((rd_key == prev_key_reg) && (pend_idx_reg > prev_idx_reg));
    assign cand_take  = cand_after && (!found_reg || (rd_key > best_key_reg));
    assign emit_last  = (emit_cnt_reg == last_pos);

    // Channel outputs
    assign in_ch.ready      = (state_reg == ST_IDLE);
    assign out_ch.valid     = (state_reg == ST_EMIT);
    assign out_ch.out_x     = best_pt_reg.x;
    assign out_ch.out_y     = best_pt_reg.y;
    assign out_ch.out_z     = best_pt_reg.z;
    assign out_ch.tag_out   = best_pt_reg.tag;
    assign out_ch.dist_sq   = best_key_reg;
    assign out_ch.emit_last = emit_last;

    // Sequencer next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        pt_next        = pt_reg;
        last_next      = last_reg;
        axis_next      = axis_reg;
        acc_next       = acc_reg;
        iss_addr_next  = iss_addr_reg;
        iss_done_next  = iss_done_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        found_next     = found_reg;
        best_key_next  = best_key_reg;
        best_idx_next  = best_idx_reg;
        best_pt_next   = best_pt_reg;
        have_prev_next = have_prev_reg;
        prev_key_next  = prev_key_reg;
        prev_idx_next  = prev_idx_reg;
        emit_cnt_next  = emit_cnt_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    pt_next.x   = in_ch.pos_x;
                    pt_next.y   = in_ch.pos_y;
                    pt_next.z   = in_ch.pos_z;
                    pt_next.tag = in_ch.tag_in;
                    last_next   = in_ch.load_last;
                    axis_next   = AXIS_X;
                    acc_next    = '0;
                    state_next  = ST_SQ;
                end
            end

            ST_SQ:
            begin
                // the squaring unit is registered, so the product of the previous axis is added
                if (axis_reg != AXIS_X)
                begin
                    acc_next = acc_reg + KEY_W'(sq);
                end
                axis_next = axis_reg + 2'd1;
                if (axis_reg == AXIS_FLUSH)
                begin
                    state_next = ST_WRITE;
                end
            end

            ST_WRITE:
            begin
                if (!store_full)
                begin
                    wr_en     = 1'b1;
                    fill_next = fill_reg + FILL_W'(1);
                end
                if (last_reg)
                begin
                    iss_addr_next  = '0;
                    iss_done_next  = 1'b0;
                    found_next     = 1'b0;
                    have_prev_next = 1'b0;
                    emit_cnt_next  = '0;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                // issue reads over the set
                if (!iss_done_reg)
                begin
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = iss_addr_reg;
                    if (FILL_W'(iss_addr_reg) == last_pos)
                    begin
                        iss_done_next = 1'b1;
                    end
                    else
                    begin
                        iss_addr_next = iss_addr_reg + ADDR_W'(1);
                    end
                end
                // compare returning data against the running best
                if (pend_reg)
                begin
                    if (cand_take)
                    begin
                        found_next    = 1'b1;
                        best_key_next = rd_key;
                        best_idx_next = pend_idx_reg;
                        best_pt_next  = rd_point;
                    end
                    if (FILL_W'(pend_idx_reg) == last_pos)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_EMIT:
            begin
                if (out_ch.ready)
                begin
                    if (emit_last)
                    begin
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        have_prev_next = 1'b1;
                        prev_key_next  = best_key_reg;
                        prev_idx_next  = best_idx_reg;
                        emit_cnt_next  = emit_cnt_reg + FILL_W'(1);
                        iss_addr_next  = '0;
                        iss_done_next  = 1'b0;
                        found_next     = 1'b0;
                        state_next     = ST_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            axis_reg      <= AXIS_X;
            iss_done_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            have_prev_reg <= 1'b0;
            emit_cnt_reg  <= '0;
            last_reg      <= 1'b0;
            iss_addr_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            axis_reg      <= axis_next;
            iss_done_reg  <= iss_done_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            have_prev_reg <= have_prev_next;
            emit_cnt_reg  <= emit_cnt_next;
            last_reg      <= last_next;
            iss_addr_reg  <= iss_addr_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pt_reg       <= pt_next;
        acc_reg      <= acc_next;
        pend_idx_reg <= pend_idx_next;
        best_key_reg <= best_key_next;
        best_idx_reg <= best_idx_next;
        best_pt_reg  <= best_pt_next;
        prev_key_reg <= prev_key_next;
        prev_idx_reg <= prev_idx_next;
    end

endmodule

FILE: rtl/dsfn_sq_unit.sv
// Shared squared-difference unit: registered (a - b)^2.
module dsfn_sq_unit (
    input  logic                      clk,
    input  logic signed [15:0]        a,
    input  logic signed [15:0]        b,
    output logic [dsfn_pkg::SQ_W-1:0] sq
);
    import dsfn_pkg::*;

    logic signed [16:0] diff;
    logic [15:0]        mag;
    logic [SQ_W-1:0]    sq_reg;
    logic [SQ_W-1:0]    sq_next;

    // Difference magnitude never exceeds 65535
    always_comb
    begin
        diff    = 17'(a) - 17'(b);
        mag     = diff[16] ? 16'(-diff) : diff[15:0];
        sq_next = 32'(mag) * 32'(mag);
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

    assign sq = sq_reg;

endmodule

FILE: rtl/dsfn_store.sv
// Point and key memory: one write port, one read port with registered data.
module dsfn_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  dsfn_pkg::point_t     wr_point,
    input  dsfn_pkg::key_t       wr_key,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output dsfn_pkg::point_t     rd_point,
    output dsfn_pkg::key_t       rd_key
);
    import dsfn_pkg::*;

    point_t point_mem [DEPTH];
    key_t   key_mem   [DEPTH];
    point_t rd_point_reg;
    key_t   rd_key_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            point_mem[wr_addr] <= wr_point;
            key_mem[wr_addr]   <= wr_key;
        end
    end

    // Read port, data registered in the cycle after the address
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_point_reg <= point_mem[rd_addr];
            rd_key_reg   <= key_mem[rd_addr];
        end
    end

    assign rd_point = rd_point_reg;
    assign rd_key   = rd_key_reg;

endmodule

FILE: sim/dsfn_sort_check.sv
`timescale 1ns / 100ps
// Far-to-near sort checker: tracks loads and reference writes, predicts and compares results.
module dsfn_sort_check #(
    parameter int MAX_POINTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    dsfn_in_if          in_mon,
    dsfn_out_if         out_mon,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          n_errors,
    output int          n_pending,
    output int          n_results,
    output int          n_sets
);
    import dsfn_pkg::*;

    // One loaded point with its squared distance, and the end-of-set flag once sorted
    typedef struct {
        point_t pt;
        key_t   sq_key;
        logic   last;
    } ranked_point_t;

    ranked_point_t loaded_set[$];
    ranked_point_t due_out[$];

    logic signed [15:0] ref_x, ref_y, ref_z;
    int err_cnt, res_cnt, set_cnt;

    // Exact squared distance in units of 2^-8
    function automatic key_t dist_to_ref(point_t p);
        longint dx, dy, dz;
        dx = longint'($signed(p.x)) - longint'(ref_x);
        dy = longint'($signed(p.y)) - longint'(ref_y);
        dz = longint'($signed(p.z)) - longint'(ref_z);
        return key_t'(dx * dx + dy * dy + dz * dz);
    endfunction

    task automatic cmp_field(input string what, input logic signed [34:0] want,
                             input logic signed [34:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            err_cnt++;
        end
    endtask

    // Store the point (unless full); on load_last rank the set farthest first
    task automatic take_point();
        ranked_point_t entry;
        ranked_point_t ordered[$];
        int pos;
        entry.pt.x   = in_mon.pos_x;
        entry.pt.y   = in_mon.pos_y;
        entry.pt.z   = in_mon.pos_z;
        entry.pt.tag = in_mon.tag_in;
        entry.sq_key = dist_to_ref(entry.pt);
        entry.last   = 1'b0;
        if (loaded_set.size() < MAX_POINTS)
            loaded_set = {loaded_set, entry};
        if (in_mon.load_last) begin
            // stable: a new point goes behind every point at equal or larger distance
            foreach (loaded_set[i]) begin
                pos = 0;
                while (pos < ordered.size() && ordered[pos].sq_key >= loaded_set[i].sq_key)
                    pos++;
                ordered.insert(pos, loaded_set[i]);
            end
            ordered[ordered.size() - 1].last = 1'b1;
            due_out = {due_out, ordered};
            loaded_set.delete();
            set_cnt++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        ranked_point_t want;
        if (!rst_n) begin
            loaded_set.delete();
            due_out.delete();
            ref_x = '0;
            ref_y = '0;
            ref_z = '0;
            err_cnt = 0;
            res_cnt = 0;
            set_cnt = 0;
            n_errors  <= 0;
            n_pending <= 0;
            n_results <= 0;
            n_sets    <= 0;
        end
        else begin
            // result transfer against the oldest expectation
            if (out_mon.valid && out_mon.ready) begin
                if (due_out.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got tag %0d dist %0d",
                             $time, out_mon.tag_out, out_mon.dist_sq);
                    err_cnt++;
                end
                else begin
                    want = due_out.pop_front();
                    cmp_field("out_x", want.pt.x, out_mon.out_x);
                    cmp_field("out_y", want.pt.y, out_mon.out_y);
                    cmp_field("out_z", want.pt.z, out_mon.out_z);
                    cmp_field("tag_out", want.pt.tag, out_mon.tag_out);
                    cmp_field("dist_sq", want.sq_key, out_mon.dist_sq);
                    cmp_field("emit_last", want.last, out_mon.emit_last);
                end
                res_cnt++;
            end

            // point transfer uses the reference as it stood before this edge
            if (in_mon.valid && in_mon.ready)
                take_point();

            // reference register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_REF_X: ref_x = pwdata[15:0];
                    REG_REF_Y: ref_y = pwdata[15:0];
                    REG_REF_Z: ref_z = pwdata[15:0];
                    default: ;
                endcase
            end

            n_errors  <= err_cnt;
            n_pending <= due_out.size();
            n_results <= res_cnt;
            n_sets    <= set_cnt;
        end
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Testbench top for the far-to-near distance sorter: clock, reset, stimulus and verdict.
module tb;
    import dsfn_pkg::*;

    localparam int MAX_POINTS   = 64;
    localparam int LOAD_CYCLES  = 10;   // covers a point load, with margin
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 24;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dsfn_in_if  in_ch();
    dsfn_out_if out_ch();

    int errors, pending, results, sets;
    int points_sent, ref_writes;
    int hold_reqs, holds_done, hold_left;
    bit steady;
    logic signed [15:0] ref_now [3];

    distance_sort_far_to_near_core #(
        .MAX_POINTS(MAX_POINTS)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dsfn_sort_check #(
        .MAX_POINTS(MAX_POINTS)
    ) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_mon    (in_ch),
        .out_mon   (out_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .n_errors  (errors),
        .n_pending (pending),
        .n_results (results),
        .n_sets    (sets)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // result side: random back-pressure, requested long hold-offs, steady stretches
    always @(posedge clk)
    begin
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_done < hold_reqs) begin
            out_ch.ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
        else begin
            out_ch.ready <= steady || ($urandom_range(99) >= 19);
        end
    end

    // offer one point, with random gaps before it; returns at its transfer edge
    task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic signed [15:0] z, input logic [5:0] tag,
                              input logic last);
        while (!steady && $urandom_range(99) < 19) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.pos_x     <= x;
        in_ch.pos_y     <= y;
        in_ch.pos_z     <= z;
        in_ch.tag_in    <= tag;
        in_ch.load_last <= last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        points_sent++;
    endtask

    // APB write: setup and access phases, then the bus goes idle
    task automatic write_reg(input logic [1:0] idx, input logic signed [15:0] val);
        in_ch.valid <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{16{val[15]}}, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ref_now[idx] = val;
        ref_writes++;
        @(posedge clk);
    endtask

    task automatic write_ref(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z);
        write_reg(REG_REF_X, x);
        write_reg(REG_REF_Y, y);
        write_reg(REG_REF_Z, z);
    endtask

    // stop offering until every expected result is in and the block is idle
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LOAD_CYCLES) @(posedge clk);
    endtask

    // full-range, near the reference (ties), or corner values
    function automatic logic signed [15:0] pick_coord(input int axis);
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 16'($urandom);
        if (r < 80)
            return ref_now[axis] + 16'(16 * ($urandom_range(6) - 3));
        case ($urandom_range(3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'shFFFF;
        endcase
    endfunction

    function automatic logic signed [15:0] pick_ref();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // one set of n random points, last one flagged; optional reference change midway
    task automatic send_set(input int n, input bit shift_ref);
        for (int i = 0; i < n; i++) begin
            if (shift_ref && i > 0 && i == n / 2) begin
                in_ch.valid <= 1'b0;
                repeat (LOAD_CYCLES) @(posedge clk);
                write_reg(2'($urandom_range(2)), pick_ref());
            end
            send_point(pick_coord(0), pick_coord(1), pick_coord(2),
                       6'($urandom_range(63)), i == n - 1);
        end
    endtask

    initial
    begin
        int n, r, set_no, random_pts;

        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.pos_x     <= '0;
        in_ch.pos_y     <= '0;
        in_ch.pos_z     <= '0;
        in_ch.tag_in    <= '0;
        in_ch.load_last <= 1'b0;
        steady          <= 1'b0;
        hold_reqs       <= 0;
        ref_now = '{16'sd0, 16'sd0, 16'sd0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-point set against the reset reference
        send_point(16'sh7FFF, 16'sh8000, 16'sh0000, 6'd63, 1'b1);
        settle();

        // reference at the top corner: largest distance, zero distance, a tie,
        // then the reference moves in the middle of the set
        write_ref(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_point(16'sh8000, 16'sh8000, 16'sh8000, 6'd0, 1'b0);
        send_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 6'd1, 1'b0);
        send_point(16'sh7FEF, 16'sh7FFF, 16'sh7FFF, 6'd2, 1'b0);
        send_point(16'sh7FFF, 16'sh7FEF, 16'sh7FFF, 6'd3, 1'b0);
        in_ch.valid <= 1'b0;
        repeat (LOAD_CYCLES) @(posedge clk);
        write_reg(REG_REF_X, 16'sh8000);
        send_point(16'sh8000, 16'sh7FFF, 16'sh7FFF, 6'd4, 1'b0);
        send_point(16'sh0000, 16'sh0000, 16'sh0000, 6'd5, 1'b1);
        settle();

        // reference at the bottom corner, identical points tie
        write_ref(16'sh8000, 16'sh8000, 16'sh8000);
        send_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 6'd6, 1'b0);
        send_point(16'sh8000, 16'sh8000, 16'sh8000, 6'd7, 1'b0);
        send_point(16'sd100, -16'sd100, 16'sd5, 6'd8, 1'b0);
        send_point(16'sd100, -16'sd100, 16'sd5, 6'd9, 1'b0);
        send_point(-16'sd1, 16'sd0, 16'sd1, 6'd10, 1'b1);
        settle();

        // long output hold-off while the sender keeps offering the next set
        write_ref(16'sd0, 16'sd0, 16'sd0);
        hold_reqs <= hold_reqs + 1;
        send_set(3, 1'b0);
        send_set(5, 1'b0);
        settle();

        // overfull set with no idling on either side: points beyond the store
        // depth are dropped
        write_ref(pick_ref(), pick_ref(), pick_ref());
        steady <= 1'b1;
        send_set(MAX_POINTS + 2, 1'b0);
        settle();
        steady <= 1'b0;

        // random sets, mostly small; reference rewritten between some of them
        set_no = 0;
        random_pts = 0;
        while (random_pts < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (r < 70)
                n = $urandom_range(6, 1);
            else if (r < 95)
                n = $urandom_range(16, 7);
            else
                n = $urandom_range(40, 30);
            if (n > RANDOM_ITEMS - random_pts)
                n = RANDOM_ITEMS - random_pts;
            send_set(n, $urandom_range(9) == 0);
            random_pts += n;
            if (set_no % 4 == 3) begin
                settle();
                write_ref(pick_ref(), pick_ref(), pick_ref());
            end
            set_no++;
        end
        settle();
        repeat (20) @(posedge clk);

        $display("Run covered %0d point transfers in %0d sets, %0d sorted results compared,",
                 points_sent, sets, results);
        $display("with %0d reference writes, ties, an overfull set and a long output hold-off.",
                 ref_writes);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/dsfn_pkg.sv
rtl/dsfn_if.sv
rtl/dsfn_sq_unit.sv
rtl/dsfn_store.sv
rtl/distance_sort_far_to_near_core.sv
sim/dsfn_sort_check.sv
sim/tb.sv
